// ===== rtl/mcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsc_pkg: shared types and constants for the scale conditioner
// Register indexes, operation and status codes, controller states and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mcsc_pkg;

	localparam int CHANNELS  = 24;
	localparam int MAX_BURST = 128;
	localparam int CH_W      = 5;
	localparam int CFG_W     = 24;
	localparam int IDX_W     = 2;

	localparam logic [IDX_W-1:0] REG_PRESENT  = 2'd0;
	localparam logic [IDX_W-1:0] REG_REF_MASS = 2'd1;
	localparam logic [IDX_W-1:0] REG_DEADBAND = 2'd2;
	localparam logic [IDX_W-1:0] REG_MIN_SPAN = 2'd3;

	localparam logic [1:0] OP_MEASURE = 2'd0;
	localparam logic [1:0] OP_ZERO    = 2'd1;
	localparam logic [1:0] OP_SPAN    = 2'd2;
	localparam logic [1:0] OP_RSVD    = 2'd3;

	localparam logic [2:0] ST_WEIGHT   = 3'd0;
	localparam logic [2:0] ST_ABSENT   = 3'd1;
	localparam logic [2:0] ST_TARE     = 3'd2;
	localparam logic [2:0] ST_SPAN     = 3'd3;
	localparam logic [2:0] ST_SPAN_REJ = 3'd4;

	// average divide: 32-bit magnitude by 8-bit count
	localparam int AVG_STEPS = 32;
	// weight divide: 45-bit magnitude by 25-bit span
	localparam int NUM_W     = 45;

	typedef enum logic [2:0] {
		S_COLLECT,
		S_AVG_DIV,
		S_PREP,
		S_MUL,
		S_WDIV,
		S_FINISH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accum;      // add accepted sample to the burst
		logic start_avg;  // load average divider
		logic avg_step;
		logic prep;       // resolve fallback, read tables
		logic mul;        // form product
		logic wdiv_step;
		logic finish;     // write tables, build result
	} cmd_t;

	typedef struct packed {
		logic avg_done;
		logic wdiv_done;
		logic need_weigh;
		logic drop;       // reserved op: no result
	} sts_t;

endpackage

// ===== rtl/multi_channel_scale_conditioner.sv =====
// ----------------------------------------------------------------------------
// multi_channel_scale_conditioner: load-cell tare and span conditioner
// Averages sample bursts per channel and reports weight or calibration status.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carries one sample beat. A beat with
// last_of_burst set closes the burst; its operation and channel apply.
// Output channel: out_valid / out_stall carries one result beat per burst
// end (none for the reserved operation, none for other beats).
// Samples inside a burst are taken one per cycle. A burst end runs the
// 32-step average divider, and for a measure on a present channel with a
// nonzero span also the 45-step weight divider, before the result beat;
// in_stall stays high until that beat is taken.
// A stalled result holds, and no new beat is taken meanwhile.
// Reset clears the burst, loads default registers and calibration tables
// (tare 0, span 100) at once.
// Configuration writes take effect on the next edge; write only while idle.
// ----------------------------------------------------------------------------
module multi_channel_scale_conditioner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcsc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [mcsc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [mcsc_pkg::CH_W-1:0]     channel,
	input  logic signed [23:0]            raw_sample,
	input  logic                          sample_valid,
	input  logic                          last_of_burst,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mcsc_pkg::CH_W-1:0]     result_channel,
	output logic [2:0]                    status,
	output logic signed [31:0]            weight_cg,
	output logic signed [23:0]            raw_average,
	output logic                          fresh
);
	import mcsc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mcsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last_of_burst),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mcsc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.channel        (channel),
		.raw_sample     (raw_sample),
		.sample_valid   (sample_valid),
		.result_channel (result_channel),
		.status         (status),
		.weight_cg      (weight_cg),
		.raw_average    (raw_average),
		.fresh          (fresh)
	);

endmodule

// ===== rtl/mcsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcsc_ctrl: burst sequencer
// Accepts samples, runs the divides at burst end and holds the result beat.
// ----------------------------------------------------------------------------
module mcsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  mcsc_pkg::sts_t sts,
	output mcsc_pkg::cmd_t cmd
);
	import mcsc_pkg::*;

	state_t state_q, state_nxt;
	logic   acc;

	assign acc = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_COLLECT: if (acc && last) state_nxt = S_AVG_DIV;
			S_AVG_DIV: if (sts.avg_done) state_nxt = S_PREP;
			S_PREP:    begin
				if (sts.drop) state_nxt = S_COLLECT;
				else if (sts.need_weigh) state_nxt = S_MUL;
				else state_nxt = S_FINISH;
			end
			S_MUL:     state_nxt = S_WDIV;
			S_WDIV:    if (sts.wdiv_done) state_nxt = S_FINISH;
			S_FINISH:  state_nxt = S_OUT;
			S_OUT:     if (!out_stall) state_nxt = S_COLLECT;
			default:   state_nxt = S_COLLECT;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != S_COLLECT);
		out_valid     = (state_q == S_OUT);
		cmd           = '0;
		cmd.accum     = acc;
		cmd.start_avg = acc && last;
		case (state_q)
			S_AVG_DIV: cmd.avg_step  = 1'b1;
			S_PREP:    cmd.prep      = 1'b1;
			S_MUL:     cmd.mul       = 1'b1;
			S_WDIV:    cmd.wdiv_step = 1'b1;
			S_FINISH:  cmd.finish    = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_COLLECT;
		else state_q <= state_nxt;
	end

endmodule

// ===== rtl/mcsc_datapath.sv =====
// ----------------------------------------------------------------------------
// mcsc_datapath: accumulator, serial dividers, tables and result register
// Restoring dividers work on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcsc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcsc_pkg::cmd_t                cmd,
	output mcsc_pkg::sts_t                sts,
	input  logic                          cfg_we,
	input  logic [mcsc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [mcsc_pkg::CFG_W-1:0]    cfg_data,
	input  logic [1:0]                    operation,
	input  logic [mcsc_pkg::CH_W-1:0]     channel,
	input  logic signed [23:0]            raw_sample,
	input  logic                          sample_valid,
	output logic [mcsc_pkg::CH_W-1:0]     result_channel,
	output logic [2:0]                    status,
	output logic signed [31:0]            weight_cg,
	output logic signed [23:0]            raw_average,
	output logic                          fresh
);
	import mcsc_pkg::*;

	logic [23:0] present_q;
	logic [19:0] ref_mass_q;
	logic [15:0] deadband_q;
	logic [23:0] min_span_q;

	logic signed [23:0] tare_q [CHANNELS];
	logic signed [24:0] span_q [CHANNELS];
	logic signed [23:0] lraw_q [CHANNELS];

	logic signed [31:0] sum_q;
	logic [7:0]         cnt_q;
	logic [1:0]         op_q;
	logic [CH_W-1:0]    ch_q;

	// average divider
	logic [31:0] aquo_q;
	logic [7:0]  arem_q;
	logic [7:0]  adiv_q;
	logic        aneg_q, afresh_q;
	logic [5:0]  astep_q;
	logic [8:0]  atrial;

	logic signed [23:0] avg_q;
	logic signed [24:0] span_r_q, diff_q;
	logic               present_q1;
	logic               ch_ok;
	logic [4:0]         chi;

	// weight divider
	logic [NUM_W-1:0]   wquo_q;
	logic [24:0]        wrem_q;
	logic [24:0]        wdiv_q;
	logic               wneg_q;
	logic [5:0]         wstep_q;
	logic [25:0]        wtrial;
	logic signed [45:0] prod;

	logic signed [31:0] wfinal;
	logic [NUM_W-1:0]   wmag;
	logic [24:0]        dmag;

	assign ch_ok = (ch_q < CH_W'(CHANNELS));
	assign chi   = ch_ok ? ch_q : '0;

	assign sts.avg_done   = (astep_q == 6'(AVG_STEPS));
	assign sts.wdiv_done  = (wstep_q == 6'(NUM_W));
	assign sts.drop       = (op_q == OP_RSVD);
	assign sts.need_weigh = (op_q == OP_MEASURE) && ch_ok && present_q[chi] &&
		(span_q[chi] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			ref_mass_q <= 20'd10000;
			deadband_q <= 16'd5;
			min_span_q <= 24'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESENT:  present_q  <= cfg_data;
				REG_REF_MASS: ref_mass_q <= cfg_data[19:0];
				REG_DEADBAND: deadband_q <= cfg_data[15:0];
				REG_MIN_SPAN: min_span_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.start_avg) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.accum && sample_valid && cnt_q < 8'(MAX_BURST)) begin
			sum_q <= sum_q + 32'(raw_sample);
			cnt_q <= cnt_q + 8'd1;
		end
	end

	// the burst-ending sample is folded in when the divider loads
	logic               last_add;
	logic signed [31:0] sum_fin;
	logic [7:0]         cnt_fin;
	assign last_add = sample_valid && cnt_q < 8'(MAX_BURST);
	assign sum_fin  = last_add ? sum_q + 32'(raw_sample) : sum_q;
	assign cnt_fin  = last_add ? cnt_q + 8'd1 : cnt_q;
	assign atrial   = {arem_q, aquo_q[31]};

	always_ff @(posedge clk) begin
		if (cmd.start_avg) begin
			op_q     <= operation;
			ch_q     <= channel;
			aneg_q   <= sum_fin[31];
			aquo_q   <= sum_fin[31] ? 32'(-sum_fin) : sum_fin;
			arem_q   <= '0;
			adiv_q   <= cnt_fin;
			afresh_q <= (cnt_fin != '0);
			astep_q  <= '0;
		end else if (cmd.avg_step && !sts.avg_done) begin
			if (adiv_q != '0 && atrial >= {1'b0, adiv_q}) begin
				arem_q <= 8'(atrial - {1'b0, adiv_q});
				aquo_q <= {aquo_q[30:0], 1'b1};
			end else begin
				arem_q <= atrial[7:0];
				aquo_q <= {aquo_q[30:0], 1'b0};
			end
			astep_q <= astep_q + 6'd1;
		end
	end

	// fallback, table reads and span difference
	logic signed [23:0] avg_sel;
	logic [31:0]        aq_s;
	assign aq_s    = aneg_q ? -aquo_q : aquo_q;
	assign avg_sel = afresh_q ? aq_s[23:0] : lraw_q[chi];

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			present_q1 <= ch_ok && present_q[chi];
			avg_q      <= avg_sel;
			span_r_q   <= span_q[chi];
			diff_q     <= 25'(avg_sel) - 25'(tare_q[chi]);
		end
	end

	assign prod   = 46'(diff_q) * $signed({1'b0, 26'(ref_mass_q)});
	assign wtrial = {wrem_q, wquo_q[NUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			wneg_q  <= prod[45] ^ span_r_q[24];
			wquo_q  <= prod[45] ? NUM_W'(-prod) : NUM_W'(prod);
			wdiv_q  <= span_r_q[24] ? 25'(-span_r_q) : 25'(span_r_q);
			wrem_q  <= '0;
			wstep_q <= '0;
		end else if (cmd.wdiv_step && !sts.wdiv_done) begin
			if (wtrial >= {1'b0, wdiv_q}) begin
				wrem_q <= 25'(wtrial - {1'b0, wdiv_q});
				wquo_q <= {wquo_q[NUM_W-2:0], 1'b1};
			end else begin
				wrem_q <= wtrial[24:0];
				wquo_q <= {wquo_q[NUM_W-2:0], 1'b0};
			end
			wstep_q <= wstep_q + 6'd1;
		end
	end

	// saturate on magnitude, then apply sign and deadband
	always_comb begin
		wmag = wquo_q;
		if (!wneg_q && wmag > NUM_W'(32'h7fffffff)) wfinal = 32'h7fffffff;
		else if (wneg_q && wmag >= NUM_W'(33'h080000000)) wfinal = 32'h80000000;
		else wfinal = wneg_q ? -wmag[31:0] : wmag[31:0];
		if (!wneg_q ? (wmag < NUM_W'(deadband_q)) : (wmag < NUM_W'(deadband_q)))
			wfinal = '0;
	end

	assign dmag = diff_q[24] ? 25'(-diff_q) : diff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				tare_q[i] <= '0;
				span_q[i] <= 25'sd100;
				lraw_q[i] <= '0;
			end
		end else if (cmd.finish) begin
			if (!present_q1) begin
				if (op_q == OP_MEASURE && ch_ok) lraw_q[chi] <= '0;
			end else begin
				case (op_q)
					OP_MEASURE: lraw_q[chi] <= avg_q;
					OP_ZERO: begin
						tare_q[chi] <= avg_q;
						lraw_q[chi] <= avg_q;
					end
					OP_SPAN: if (dmag >= 25'(min_span_q)) span_q[chi] <= diff_q;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_channel <= ch_q;
			if (!present_q1) begin
				status      <= ST_ABSENT;
				weight_cg   <= '0;
				raw_average <= '0;
				fresh       <= 1'b0;
			end else begin
				raw_average <= avg_q;
				fresh       <= afresh_q;
				case (op_q)
					OP_MEASURE: begin
						status    <= ST_WEIGHT;
						weight_cg <= (span_r_q != '0) ? wfinal : '0;
					end
					OP_ZERO: begin
						status    <= ST_TARE;
						weight_cg <= '0;
					end
					default: begin
						status    <= (dmag < 25'(min_span_q)) ? ST_SPAN_REJ : ST_SPAN;
						weight_cg <= '0;
					end
				endcase
			end
		end
	end

endmodule
